// File: sv/bsdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsdc_pkg
// Shared types and constants of the block-storage DMA controller.
// ----------------------------------------------------------------------------
package bsdc_pkg;

   localparam int unsigned BLOCK_BYTES_DEF   = 512;
   localparam int unsigned MEM_ADDR_BITS_DEF = 24;

   // Transaction modes on the request channel
   localparam logic [2:0] MODE_READ  = 3'd0;
   localparam logic [2:0] MODE_PEEK  = 3'd1;
   localparam logic [2:0] MODE_WRITE = 3'd2;
   localparam logic [2:0] MODE_BYTE  = 3'd3;
   localparam logic [2:0] MODE_SLOT  = 3'd4;

   // Register offsets
   localparam logic [7:0] REG_BLK0   = 8'd1;
   localparam logic [7:0] REG_BLK1   = 8'd2;
   localparam logic [7:0] REG_BLK2   = 8'd3;
   localparam logic [7:0] REG_BLK3   = 8'd4;
   localparam logic [7:0] REG_ADDR0  = 8'd5;
   localparam logic [7:0] REG_ADDR1  = 8'd6;
   localparam logic [7:0] REG_ADDR2  = 8'd7;
   localparam logic [7:0] REG_NBLK   = 8'd8;
   localparam logic [7:0] REG_CMD    = 8'd9;
   localparam logic [7:0] REG_DATA   = 8'd10;

   // Command codes
   localparam logic [2:0] CMD_FETCH  = 3'd1;
   localparam logic [2:0] CMD_STORE  = 3'd2;
   localparam logic [2:0] CMD_LOAD   = 3'd3;
   localparam logic [2:0] CMD_REWIND = 3'd4;

   // Configuration register indexes
   localparam logic CSR_PRESENT  = 1'b0;
   localparam logic CSR_CAPACITY = 1'b1;

   typedef enum logic [2:0] {
      OP_READ, OP_PEEK, OP_WRITE, OP_BYTE, OP_SLOT, OP_NONE
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  offset;
      logic [7:0]  data;
   } op_type;

endpackage

`default_nettype wire

// File: sv/bsdc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsdc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bsdc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata <= mem_ff[addr];
         end
      end
   end

endmodule

`default_nettype wire

// File: sv/bsdc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsdc_front
// Accept and classify request transactions into a two-entry queue.
// ----------------------------------------------------------------------------
module bsdc_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             hold,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire logic [2:0]       req_mode,
   input  wire logic [7:0]       req_reg_offset,
   input  wire logic [7:0]       req_write_value,
   input  wire logic [7:0]       req_card_byte,
   output      logic             q_valid,
   output      bsdc_pkg::op_type q_op,
   input  wire logic             q_pop
);

   bsdc_pkg::op_type slot_ff [2];
   logic             wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   bsdc_pkg::op_type op;
   logic             push;

   always_comb begin
      op.offset = req_reg_offset;
      op.data   = req_write_value;
      case (req_mode)
         bsdc_pkg::MODE_READ:  op.kind = bsdc_pkg::OP_READ;
         bsdc_pkg::MODE_PEEK:  op.kind = bsdc_pkg::OP_PEEK;
         bsdc_pkg::MODE_WRITE: op.kind = bsdc_pkg::OP_WRITE;
         bsdc_pkg::MODE_BYTE: begin
            op.kind = bsdc_pkg::OP_BYTE;
            op.data = req_card_byte;
         end
         bsdc_pkg::MODE_SLOT:  op.kind = bsdc_pkg::OP_SLOT;
         default:              op.kind = bsdc_pkg::OP_NONE;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2) && !hold;
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_op      = slot_ff[rd_ff];
   assign wr_in     = push ? !wr_ff : wr_ff;
   assign rd_in     = q_pop ? !rd_ff : rd_ff;
   assign cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= op;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/bsdc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsdc_back
// Execute queued transactions: register file, transfers, buffer and result.
// ----------------------------------------------------------------------------
module bsdc_back #(
   parameter int unsigned BLOCK_BYTES   = bsdc_pkg::BLOCK_BYTES_DEF,
   parameter int unsigned MEM_ADDR_BITS = bsdc_pkg::MEM_ADDR_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     card_present,
   input  wire logic [32:0]              capacity_blocks,
   input  wire logic                     q_valid,
   input  wire bsdc_pkg::op_type         q_op,
   output      logic                     q_pop,
   output      logic                     clearing,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic [7:0]               rsp_read_data,
   output      logic                     rsp_mem_write_valid,
   output      logic [MEM_ADDR_BITS-1:0] rsp_mem_address,
   output      logic [7:0]               rsp_mem_byte,
   output      logic                     rsp_card_req_valid,
   output      logic                     rsp_card_req_write,
   output      logic [31:0]              rsp_card_block,
   output      logic                     rsp_card_write_valid,
   output      logic [7:0]               rsp_card_write_byte
);

   localparam int unsigned PW = $clog2(BLOCK_BYTES);
   localparam logic [PW-1:0] LAST = PW'(BLOCK_BYTES - 1);

   typedef enum logic [1:0] {PH_IDLE, PH_DMA, PH_FILL, PH_SEND} phase_type;

   phase_type                phase_ff, phase_in;
   logic [31:0]              bn_ff, bn_in, wblk_ff, wblk_in;
   logic [23:0]              da_ff, da_in;
   logic [7:0]               cnt_ff, cnt_in, left_ff, left_in;
   logic                     err_ff, err_in;
   logic [PW-1:0]            ptr_ff, ptr_in, bcnt_ff, bcnt_in, clr_ff, clr_in;
   logic [MEM_ADDR_BITS-1:0] wa_ff, wa_in;
   logic                     clearing_ff, clearing_in;

   // result register
   logic                     rv_ff, rv_in;
   logic [7:0]               rd_ff, rd_in;
   logic                     rd_ram_ff, rd_ram_in;
   logic                     mv_ff, mv_in;
   logic [MEM_ADDR_BITS-1:0] ma_ff, ma_in;
   logic [7:0]               mb_ff, mb_in;
   logic                     cv_ff, cv_in, cw_ff, cw_in;
   logic [31:0]              cb_ff, cb_in;
   logic                     wv_ff, wv_in;

   logic                     ram_en, ram_we;
   logic [PW-1:0]            ram_addr;
   logic [7:0]               ram_wd, ram_rd;
   logic                     go;
   logic [MEM_ADDR_BITS+23:0] da_wide;
   logic [31:0]              nblk;
   logic [2:0]               code;

   function automatic logic blk_ok(input logic pres, input logic [32:0] cap,
                                   input logic [31:0] b);
      return pres && ({1'b0, b} < cap);
   endfunction

   function automatic logic [PW-1:0] step(input logic [PW-1:0] i);
      return (i == LAST) ? '0 : i + 1'b1;
   endfunction

   assign da_wide  = {{MEM_ADDR_BITS{1'b0}}, da_ff};
   assign nblk     = wblk_ff + 32'd1;
   assign code     = q_op.data[2:0];
   assign go       = q_valid && !clearing_ff && (!rv_ff || rsp_ready);
   assign q_pop    = go;
   assign clearing = clearing_ff;

   always_comb begin
      phase_in = phase_ff; bn_in = bn_ff; wblk_in = wblk_ff; da_in = da_ff;
      cnt_in = cnt_ff; left_in = left_ff; err_in = err_ff; ptr_in = ptr_ff;
      bcnt_in = bcnt_ff; wa_in = wa_ff; clr_in = clr_ff;
      clearing_in = clearing_ff;
      rv_in = rsp_ready ? 1'b0 : rv_ff;
      rd_in = rd_ff; rd_ram_in = rd_ram_ff; mv_in = mv_ff; ma_in = ma_ff;
      mb_in = mb_ff; cv_in = cv_ff; cw_in = cw_ff; cb_in = cb_ff; wv_in = wv_ff;
      ram_en = 1'b0; ram_we = 1'b0; ram_addr = ptr_ff; ram_wd = q_op.data;

      if (clearing_ff) begin
         ram_en = 1'b1; ram_we = 1'b1; ram_addr = clr_ff; ram_wd = 8'd0;
         clr_in = step(clr_ff);
         if (clr_ff == LAST) begin
            clearing_in = 1'b0;
         end
      end else if (go) begin
         rv_in = 1'b1;
         rd_in = 8'd0; rd_ram_in = 1'b0; mv_in = 1'b0; ma_in = '0; mb_in = 8'd0;
         cv_in = 1'b0; cw_in = 1'b0; cb_in = 32'd0; wv_in = 1'b0;
         case (q_op.kind)
            bsdc_pkg::OP_READ, bsdc_pkg::OP_PEEK: begin
               case (q_op.offset)
                  bsdc_pkg::REG_BLK0:  rd_in = bn_ff[7:0];
                  bsdc_pkg::REG_BLK1:  rd_in = bn_ff[15:8];
                  bsdc_pkg::REG_BLK2:  rd_in = bn_ff[23:16];
                  bsdc_pkg::REG_BLK3:  rd_in = bn_ff[31:24];
                  bsdc_pkg::REG_ADDR0: rd_in = da_ff[7:0];
                  bsdc_pkg::REG_ADDR1: rd_in = da_ff[15:8];
                  bsdc_pkg::REG_ADDR2: rd_in = da_ff[23:16];
                  bsdc_pkg::REG_NBLK:  rd_in = cnt_ff;
                  bsdc_pkg::REG_CMD:
                     rd_in = {card_present, 5'd0, err_ff, phase_ff != PH_IDLE};
                  bsdc_pkg::REG_DATA: begin
                     ram_en = 1'b1;
                     rd_ram_in = 1'b1;
                     if (q_op.kind == bsdc_pkg::OP_READ) begin
                        ptr_in = step(ptr_ff);
                     end
                  end
                  default: rd_in = 8'd0;
               endcase
            end
            bsdc_pkg::OP_WRITE: begin
               case (q_op.offset)
                  bsdc_pkg::REG_BLK0:  bn_in[7:0]   = q_op.data;
                  bsdc_pkg::REG_BLK1:  bn_in[15:8]  = q_op.data;
                  bsdc_pkg::REG_BLK2:  bn_in[23:16] = q_op.data;
                  bsdc_pkg::REG_BLK3:  bn_in[31:24] = q_op.data;
                  bsdc_pkg::REG_ADDR0: da_in[7:0]   = q_op.data;
                  bsdc_pkg::REG_ADDR1: da_in[15:8]  = q_op.data;
                  bsdc_pkg::REG_ADDR2: da_in[23:16] = q_op.data;
                  bsdc_pkg::REG_NBLK:  cnt_in       = q_op.data;
                  bsdc_pkg::REG_CMD: begin
                     // abandon any transfer and rewind before acting
                     err_in = 1'b0; ptr_in = '0; phase_in = PH_IDLE; bcnt_in = '0;
                     case (code)
                        bsdc_pkg::CMD_FETCH: begin
                           if (cnt_ff != 8'd0) begin
                              if (!blk_ok(card_present, capacity_blocks, bn_ff)) begin
                                 err_in = 1'b1;
                              end else begin
                                 wblk_in  = bn_ff;
                                 wa_in    = da_wide[MEM_ADDR_BITS-1:0];
                                 left_in  = cnt_ff;
                                 phase_in = PH_DMA;
                                 cv_in    = 1'b1;
                                 cb_in    = bn_ff;
                              end
                           end
                        end
                        bsdc_pkg::CMD_STORE, bsdc_pkg::CMD_LOAD: begin
                           if (!blk_ok(card_present, capacity_blocks, bn_ff)) begin
                              err_in = 1'b1;
                           end else begin
                              wblk_in  = bn_ff;
                              phase_in = (code == bsdc_pkg::CMD_LOAD) ? PH_FILL
                                                                      : PH_SEND;
                              cv_in    = 1'b1;
                              cw_in    = (code == bsdc_pkg::CMD_STORE);
                              cb_in    = bn_ff;
                           end
                        end
                        bsdc_pkg::CMD_REWIND: ;
                        default: err_in = 1'b1;
                     endcase
                  end
                  bsdc_pkg::REG_DATA: begin
                     ram_en = 1'b1; ram_we = 1'b1;
                     ptr_in = step(ptr_ff);
                  end
                  default: ;
               endcase
            end
            bsdc_pkg::OP_BYTE: begin
               if (phase_ff == PH_DMA) begin
                  mv_in = 1'b1; ma_in = wa_ff; mb_in = q_op.data;
                  wa_in = wa_ff + 1'b1;
                  if (bcnt_ff == LAST) begin
                     bcnt_in = '0;
                     left_in = left_ff - 8'd1;
                     wblk_in = nblk;
                     if (left_ff == 8'd1) begin
                        phase_in = PH_IDLE;
                     end else if (!blk_ok(card_present, capacity_blocks, nblk)) begin
                        err_in   = 1'b1;
                        phase_in = PH_IDLE;
                     end else begin
                        cv_in = 1'b1;
                        cb_in = nblk;
                     end
                  end else begin
                     bcnt_in = bcnt_ff + 1'b1;
                  end
               end else if (phase_ff == PH_FILL) begin
                  ram_en = 1'b1; ram_we = 1'b1; ram_addr = bcnt_ff;
                  bcnt_in = step(bcnt_ff);
                  if (bcnt_ff == LAST) begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            bsdc_pkg::OP_SLOT: begin
               if (phase_ff == PH_SEND) begin
                  ram_en = 1'b1; ram_addr = bcnt_ff;
                  wv_in = 1'b1;
                  bcnt_in = step(bcnt_ff);
                  if (bcnt_ff == LAST) begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= rd_in; rd_ram_ff <= rd_ram_in; ma_ff <= ma_in; mb_ff <= mb_in;
      cb_ff <= cb_in; wblk_ff <= wblk_in; wa_ff <= wa_in;
      if (reset) begin
         phase_ff <= PH_IDLE; bn_ff <= 32'd0; da_ff <= 24'd0; cnt_ff <= 8'd1;
         left_ff <= 8'd0; err_ff <= 1'b0; ptr_ff <= '0; bcnt_ff <= '0;
         clr_ff <= '0; clearing_ff <= 1'b1; rv_ff <= 1'b0;
         mv_ff <= 1'b0; cv_ff <= 1'b0; cw_ff <= 1'b0; wv_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; bn_ff <= bn_in; da_ff <= da_in; cnt_ff <= cnt_in;
         left_ff <= left_in; err_ff <= err_in; ptr_ff <= ptr_in; bcnt_ff <= bcnt_in;
         clr_ff <= clr_in; clearing_ff <= clearing_in; rv_ff <= rv_in;
         mv_ff <= mv_in; cv_ff <= cv_in; cw_ff <= cw_in; wv_ff <= wv_in;
      end
   end

   bsdc_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_buf (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wd),
      .rdata (ram_rd)
   );

   assign rsp_valid            = rv_ff;
   assign rsp_read_data        = rd_ram_ff ? ram_rd : rd_ff;
   assign rsp_mem_write_valid  = mv_ff;
   assign rsp_mem_address      = ma_ff;
   assign rsp_mem_byte         = mb_ff;
   assign rsp_card_req_valid   = cv_ff;
   assign rsp_card_req_write   = cw_ff;
   assign rsp_card_block       = cb_ff;
   assign rsp_card_write_valid = wv_ff;
   assign rsp_card_write_byte  = wv_ff ? ram_rd : 8'd0;

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !q_pop) else $error("pop during clearing pass");
   a_idle_bcnt: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> bcnt_ff == '0)
      else $error("byte count left over while idle");
   a_dma_out: assert property (@(posedge clock) disable iff (reset)
      go && q_op.kind == bsdc_pkg::OP_BYTE && phase_ff == PH_DMA
      |=> rv_ff && mv_ff) else $error("DMA byte lost");
   a_ram_one: assert property (@(posedge clock) disable iff (reset)
      rv_ff && (rd_ram_ff || wv_ff) |-> !(rd_ram_ff && wv_ff))
      else $error("two buffer reads in one result");

endmodule

`default_nettype wire

// File: sv/block_storage_dma_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_storage_dma_controller
// Byte-wide register block of a block-storage device with DMA to memory.
// ----------------------------------------------------------------------------
// Request channel (req_*): one transaction per bus access, storage byte or
// storage write slot. Response channel (rsp_*): exactly one result per
// request, in order. Both use valid/ready.
// Configuration (csr_*): write card_present (index 0) or capacity_blocks
// (index 1) while idle; taken in the cycle csr_we is high.
// An accepted request is queued, then executed into the result register.
// Throughput: one transaction per cycle when not held by rsp_ready or by the
// clearing pass; the single-port buffer RAM sees at most one access per transaction.
// A two-entry queue between the classifier and the execute stage, and the
// result register, let requests keep flowing while a result waits; when
// rsp_ready is low the execute stage holds and the queue fills, after which
// req_ready drops.
// Reset: the control registers return to their reset values, then the buffer is
// cleared over all BLOCK_BYTES addresses in a pass during which req_ready stays low.
// ----------------------------------------------------------------------------
module block_storage_dma_controller #(
   parameter int unsigned BLOCK_BYTES   = bsdc_pkg::BLOCK_BYTES_DEF,
   parameter int unsigned MEM_ADDR_BITS = bsdc_pkg::MEM_ADDR_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic                     csr_index,
   input  wire logic [32:0]              csr_wdata,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire logic [2:0]               req_mode,
   input  wire logic [7:0]               req_reg_offset,
   input  wire logic [7:0]               req_write_value,
   input  wire logic [7:0]               req_card_byte,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic [7:0]               rsp_read_data,
   output      logic                     rsp_mem_write_valid,
   output      logic [MEM_ADDR_BITS-1:0] rsp_mem_address,
   output      logic [7:0]               rsp_mem_byte,
   output      logic                     rsp_card_req_valid,
   output      logic                     rsp_card_req_write,
   output      logic [31:0]              rsp_card_block,
   output      logic                     rsp_card_write_valid,
   output      logic [7:0]               rsp_card_write_byte
);

   logic             present_ff;
   logic [32:0]      capacity_ff;
   logic             q_valid, q_pop, clearing;
   bsdc_pkg::op_type q_op;

   // Hold configuration; the user must write it only while the block is idle (not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= 1'b0;
         capacity_ff <= 33'd0;
      end else if (csr_we) begin
         case (csr_index)
            bsdc_pkg::CSR_PRESENT:  present_ff  <= csr_wdata[0];
            bsdc_pkg::CSR_CAPACITY: capacity_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Front: accept and classify, queue for the execute stage
   bsdc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .hold            (clearing),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_reg_offset  (req_reg_offset),
      .req_write_value (req_write_value),
      .req_card_byte   (req_card_byte),
      .q_valid         (q_valid),
      .q_op            (q_op),
      .q_pop           (q_pop)
   );

   // Back: register file, transfer sequencing, buffer and result register
   bsdc_back #(
      .BLOCK_BYTES   (BLOCK_BYTES),
      .MEM_ADDR_BITS (MEM_ADDR_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .card_present         (present_ff),
      .capacity_blocks      (capacity_ff),
      .q_valid              (q_valid),
      .q_op                 (q_op),
      .q_pop                (q_pop),
      .clearing             (clearing),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_read_data        (rsp_read_data),
      .rsp_mem_write_valid  (rsp_mem_write_valid),
      .rsp_mem_address      (rsp_mem_address),
      .rsp_mem_byte         (rsp_mem_byte),
      .rsp_card_req_valid   (rsp_card_req_valid),
      .rsp_card_req_write   (rsp_card_req_write),
      .rsp_card_block       (rsp_card_block),
      .rsp_card_write_valid (rsp_card_write_valid),
      .rsp_card_write_byte  (rsp_card_write_byte)
   );

endmodule

`default_nettype wire
